FILE: rtl/bmhq_pkg.sv
`default_nettype none
package bmhq_pkg;

  localparam int unsigned KeyW = 31;
  localparam int unsigned IdentW = 32;
  localparam int unsigned PayW = 48;
  localparam int unsigned EntryW = KeyW + IdentW + PayW;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OpPush = 2'd0;
  localparam opcode_t OpPop = 2'd1;
  localparam opcode_t OpFind = 2'd2;
  localparam opcode_t OpSpare = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t StOk = 2'd0;
  localparam status_t StFull = 2'd1;
  localparam status_t StEmpty = 2'd2;
  localparam status_t StMissing = 2'd3;

  // Memory read address select.
  typedef logic [1:0] rdsel_t;
  localparam rdsel_t RdCur = 2'd0;  // current slot
  localparam rdsel_t RdNear = 2'd1; // parent on the way up, left child on the way down
  localparam rdsel_t RdFar = 2'd2;  // right child
  localparam rdsel_t RdScan = 2'd3; // scan index

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdentW-1:0] ident;
    logic [PayW-1:0] pay;
  } entry_t;

  // Datapath command group issued by the controller.
  typedef struct packed {
    logic load;       // capture input word
    logic rd_en;      // issue memory read
    rdsel_t rd_sel;   // read address select
    logic cap_a;      // capture read data into A
    logic cap_b;      // capture read data into B
    logic cap_root;   // capture read data as popped entry
    logic wr_new;     // write new entry at cur
    logic wr_a_cur;   // write A at cur
    logic wr_cur_to_a; // write held entry at A's address
    logic wr_a_root;  // write A at slot 1
    logic cnt_inc;
    logic cnt_dec;
    logic set_cur_cnt;  // cur := count
    logic set_cur_root; // cur := 1
    logic cur_to_up;    // cur := parent together with wr_a_cur; also selects the parent address
    logic cur_to_kid;   // cur := chosen kid
    logic pick_b;       // choose kid+1
    logic scan_start;
    logic scan_next;
    logic res_load;
    logic [1:0] res_status;
    logic res_pos;
    logic res_pop;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic full;
    logic empty;
    logic cur_is_root;  // cur == 1
    logic kid_ok;       // 2*cur <= count
    logic kid2_ok;      // 2*cur+1 <= count
    logic a_gt_held;    // parent key > held key
    logic b_lt_a;       // key b < key a
    logic a_lt_held;    // child key < held key
    logic scan_done;    // scan index > count
    logic scan_hit;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/bmhq_datapath.sv
`default_nettype none
module bmhq_datapath #(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned AW = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire bmhq_pkg::cmd_t cmd_i,
  output bmhq_pkg::stat_t stat_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [bmhq_pkg::KeyW-1:0] cost_key_i,
  input  wire logic [bmhq_pkg::IdentW-1:0] item_ident_i,
  input  wire logic [bmhq_pkg::PayW-1:0] entry_payload_i,
  output logic [1:0] status_o,
  output logic [bmhq_pkg::KeyW-1:0] out_key_o,
  output logic [bmhq_pkg::IdentW-1:0] out_ident_o,
  output logic [bmhq_pkg::PayW-1:0] out_payload_o,
  output logic [9:0] position_o,
  output logic [9:0] occupancy_o
);
  bmhq_pkg::entry_t mem_q [SLOTS];
  bmhq_pkg::entry_t rd_q, held_q, a_q, b_q, root_q;
  bmhq_pkg::opcode_t op_q;
  logic [AW-1:0] cnt_q, cur_q, a_addr_q, rd_addr;
  logic [AW:0] scan_q;
  logic [AW:0] kid, kid2;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  bmhq_pkg::entry_t wr_data;

  assign kid = {cur_q, 1'b0};
  assign kid2 = {cur_q, 1'b1};

  always_comb begin
    unique case (cmd_i.rd_sel)
      bmhq_pkg::RdCur: rd_addr = cur_q;
      bmhq_pkg::RdNear: rd_addr = cmd_i.cur_to_up ? {1'b0, cur_q[AW-1:1]} : kid[AW-1:0];
      bmhq_pkg::RdFar: rd_addr = kid2[AW-1:0];
      bmhq_pkg::RdScan: rd_addr = scan_q[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = cur_q;
    wr_data = held_q;
    priority if (cmd_i.wr_new) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_a_cur) begin
      wr_en = 1'b1;
      wr_data = a_q;
    end else if (cmd_i.wr_cur_to_a) begin
      wr_en = 1'b1;
      wr_addr = a_addr_q;
    end else if (cmd_i.wr_a_root) begin
      wr_en = 1'b1;
      wr_addr = AW'(1);
      wr_data = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_q <= '{key: cost_key_i, ident: item_ident_i, pay: entry_payload_i};
      op_q <= opcode_i;
    end
    if (cmd_i.cap_a) begin
      a_q <= rd_q;
    end
    if (cmd_i.cap_b) begin
      b_q <= rd_q;
    end
    if (cmd_i.pick_b) begin
      a_q <= b_q;
      a_addr_q <= kid2[AW-1:0];
    end else if (cmd_i.cap_a) begin
      a_addr_q <= cmd_i.cur_to_up ? {1'b0, cur_q[AW-1:1]} : kid[AW-1:0];
    end
    if (cmd_i.cap_root) begin
      root_q <= rd_q;
    end
    if (cmd_i.wr_a_root) begin
      held_q <= a_q; // last entry becomes the sifted word
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cur_q <= '0;
      scan_q <= '0;
      status_o <= bmhq_pkg::StOk;
      out_key_o <= '0;
      out_ident_o <= '0;
      out_payload_o <= '0;
      position_o <= '0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + AW'(1);
      if (cmd_i.cnt_dec) cnt_q <= cnt_q - AW'(1);
      if (cmd_i.set_cur_cnt) cur_q <= cnt_q;
      if (cmd_i.set_cur_root) cur_q <= AW'(1);
      if (cmd_i.cur_to_up) begin
        if (cmd_i.wr_a_cur) cur_q <= {1'b0, cur_q[AW-1:1]};
      end
      if (cmd_i.cur_to_kid) cur_q <= a_addr_q;
      if (cmd_i.scan_start) scan_q <= (AW+1)'(1);
      if (cmd_i.scan_next) scan_q <= scan_q + (AW+1)'(1);
      if (cmd_i.res_load) begin
        status_o <= cmd_i.res_status;
        out_key_o <= cmd_i.res_pop ? root_q.key : '0;
        out_ident_o <= cmd_i.res_pop ? root_q.ident : '0;
        out_payload_o <= cmd_i.res_pop ? root_q.pay : '0;
        position_o <= cmd_i.res_pos ? 10'(scan_q - (AW+1)'(1)) : '0;
      end
    end
  end

  assign occupancy_o = 10'(cnt_q);

  always_comb begin
    stat_o.op = op_q;
    stat_o.full = ({1'b0, cnt_q} + (AW+1)'(1)) >= (AW+1)'(SLOTS);
    stat_o.empty = (cnt_q == '0);
    stat_o.cur_is_root = (cur_q == AW'(1));
    stat_o.kid_ok = kid <= {1'b0, cnt_q};
    stat_o.kid2_ok = kid2 <= {1'b0, cnt_q};
    stat_o.a_gt_held = a_q.key > held_q.key;
    stat_o.b_lt_a = b_q.key < a_q.key;
    stat_o.a_lt_held = a_q.key < held_q.key;
    stat_o.scan_done = scan_q > {1'b0, cnt_q};
    stat_o.scan_hit = rd_q.ident == held_q.ident;
  end
endmodule
`default_nettype wire

FILE: rtl/bmhq_ctrl.sv
`default_nettype none
module bmhq_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t cmd_o
);
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_UPRD   = 13'b0000000000100,
    S_UPCMP  = 13'b0000000001000,
    S_POPRT  = 13'b0000000010000,
    S_POPLS  = 13'b0000000100000,
    S_POPWR  = 13'b0000001000000,
    S_DNRA   = 13'b0000010000000,
    S_DNRB   = 13'b0000100000000,
    S_DNCMP  = 13'b0001000000000,
    S_SCRD   = 13'b0010000000000,
    S_SCCMP  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic wait_q, wait_d; // marks entry to a state that first captures read data or sets cur

  assign in_stall = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    wait_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.op)
          bmhq_pkg::OpPush: begin
            if (stat_i.full) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_status = bmhq_pkg::StFull;
              state_d = S_OUT;
            end else begin
              cmd_o.cnt_inc = 1'b1;
              state_d = S_UPRD;
              wait_d = 1'b1;
            end
          end
          bmhq_pkg::OpPop: begin
            if (stat_i.empty) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_status = bmhq_pkg::StEmpty;
              state_d = S_OUT;
            end else begin
              cmd_o.set_cur_root = 1'b1;
              state_d = S_POPRT;
            end
          end
          bmhq_pkg::OpFind: begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCRD;
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_status = bmhq_pkg::StOk;
            state_d = S_OUT;
          end
        endcase
      end
      // Push: first sets cur to the new slot, then reads the parent at each level.
      S_UPRD: begin
        if (wait_q) begin
          cmd_o.set_cur_cnt = 1'b1;
        end else if (stat_i.cur_is_root) begin
          cmd_o.wr_new = 1'b1;
          cmd_o.res_load = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = bmhq_pkg::RdNear;
          cmd_o.cur_to_up = 1'b1;
          state_d = S_UPCMP;
          wait_d = 1'b1;
        end
      end
      S_UPCMP: begin
        if (wait_q) begin
          cmd_o.cap_a = 1'b1;
          cmd_o.cur_to_up = 1'b1;
        end else if (stat_i.a_gt_held) begin
          cmd_o.wr_a_cur = 1'b1;
          cmd_o.cur_to_up = 1'b1;
          state_d = S_UPRD;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.res_load = 1'b1;
          state_d = S_OUT;
        end
      end
      // Pop: read root, read last, move last to root.
      S_POPRT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = bmhq_pkg::RdCur;
        state_d = S_POPLS;
        wait_d = 1'b1;
      end
      S_POPLS: begin
        if (wait_q) begin
          cmd_o.cap_root = 1'b1;
          cmd_o.set_cur_cnt = 1'b1;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = bmhq_pkg::RdCur;
          state_d = S_POPWR;
          wait_d = 1'b1;
        end
      end
      S_POPWR: begin
        if (wait_q) begin
          cmd_o.cap_a = 1'b1;
          cmd_o.cur_to_up = 1'b0;
        end else begin
          cmd_o.wr_a_root = 1'b1;
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_cur_root = 1'b1;
          state_d = S_DNRA;
        end
      end
      S_DNRA: begin
        if (!stat_i.kid_ok) begin
          cmd_o.wr_new = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_pop = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = bmhq_pkg::RdNear;
          state_d = S_DNRB;
          wait_d = 1'b1;
        end
      end
      S_DNRB: begin
        if (wait_q) begin
          cmd_o.cap_a = 1'b1;
          if (stat_i.kid2_ok) begin
            cmd_o.rd_en = 1'b1;
            cmd_o.rd_sel = bmhq_pkg::RdFar;
            state_d = S_DNCMP;
            wait_d = 1'b1;
          end else begin
            state_d = S_DNCMP;
          end
        end
      end
      S_DNCMP: begin
        if (wait_q) begin
          cmd_o.cap_b = 1'b1;
          wait_d = 1'b0;
          state_d = S_DNCMP;
        end else if (stat_i.kid2_ok && stat_i.b_lt_a) begin
          cmd_o.pick_b = 1'b1;
          state_d = S_DNCMP;
          wait_d = 1'b0;
        end else if (stat_i.a_lt_held) begin
          cmd_o.wr_a_cur = 1'b1;
          cmd_o.cur_to_kid = 1'b1;
          state_d = S_DNRA;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_pop = 1'b1;
          state_d = S_OUT;
        end
      end
      S_SCRD: begin
        if (stat_i.scan_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = bmhq_pkg::StMissing;
          state_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = bmhq_pkg::RdScan;
          cmd_o.scan_next = 1'b1;
          state_d = S_SCCMP;
        end
      end
      S_SCCMP: begin
        if (stat_i.scan_hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_pos = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SCRD;
        end
      end
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q <= wait_d;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.wr_new, cmd_o.wr_a_cur, cmd_o.wr_a_root}) <= 1)
    else $error("conflicting memory writes");
`endif
endmodule
`default_nettype wire

FILE: rtl/binary_min_heap_queue.sv
`default_nettype none
// Binary min-heap priority queue.
// Input channel: in_valid / in_stall carry one command word (opcode_i,
// cost_key_i, item_ident_i, entry_payload_i). Opcode push inserts an entry,
// pop removes the smallest key, find scans for an identifier.
// Output channel: out_valid / out_stall carry one result word per command:
// status_o, popped entry fields, position_o and occupancy_o.
// One command is in flight at a time; in_stall is high while busy.
// Rejected push, empty pop and unused opcodes answer from dispatch with no
// memory access. Push climbs a level per parent read until the parent key
// is not greater or the root is reached; pop reads root and last entry,
// then descends a level per one or two child reads; find reads one slot
// per step until a hit or past the last entry. The entry memory is read one
// slot at a time: each heap level costs one or two reads and one write.
// After a result is taken the controller returns to idle before it takes
// the next word.
// Reset clears the entry count and the controller; the entry memory holds
// no reset and is only read at slots already written.
// A stalled result holds on the outputs until taken; no new command is
// accepted until then.
module binary_min_heap_queue #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] opcode_i,
  input  wire logic [30:0] cost_key_i,
  input  wire logic [31:0] item_ident_i,
  input  wire logic [47:0] entry_payload_i,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] status_o,
  output logic [30:0] out_key_o,
  output logic [31:0] out_ident_o,
  output logic [47:0] out_payload_o,
  output logic [9:0] position_o,
  output logic [9:0] occupancy_o
);
  localparam int unsigned AW = $clog2(SLOTS);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat_i(stat), .cmd_o(cmd)
  );

  bmhq_datapath #(.SLOTS(SLOTS), .AW(AW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .opcode_i, .cost_key_i, .item_ident_i, .entry_payload_i,
    .status_o, .out_key_o, .out_ident_o, .out_payload_o,
    .position_o, .occupancy_o
  );
endmodule
`default_nettype wire
